/* rtl/core/gbe_pkg.sv */
`default_nettype none

package gbe_pkg;

  localparam int unsigned BUFFER_DEPTH = 1024;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W        = ADDR_W + 1;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 3'd0,
    FUNC_LEFT      = 3'd1,
    FUNC_RIGHT     = 3'd2,
    FUNC_BACKSPACE = 3'd3,
    FUNC_READ      = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EDGE   = 2'd1,
    ST_FULL   = 2'd2,
    ST_BEYOND = 2'd3
  } status_t;

  // Decoded request handed from the command stage to the data stage.
  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  text_len;
    logic [LEN_W-1:0]  cursor;
    logic              rd_need;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_move;
    logic [ADDR_W-1:0] wr_addr;
    logic              read_ok;
  } gbe_op_t;

endpackage

`default_nettype wire

/* rtl/core/gbe_cmd.sv */
`default_nettype none

module gbe_cmd (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [gbe_pkg::FUNC_W-1:0]  func,
  input  wire logic [gbe_pkg::POS_W-1:0]   pos,
  output gbe_pkg::gbe_op_t                 op
);
  import gbe_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] right_r, right_nxt;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] tail_idx;
  logic [CNT_W-1:0] new_len;

  always_comb begin
    total    = left_r + right_r;
    pos_ext  = CNT_W'(pos);
    tail_idx = DEPTH_CNT - right_r + pos_ext - left_r;

    left_nxt  = left_r;
    right_nxt = right_r;

    op.status  = ST_DONE;
    op.rd_need = 1'b0;
    op.rd_addr = left_r[ADDR_W-1:0];
    op.wr_en   = 1'b0;
    op.wr_move = 1'b0;
    op.wr_addr = left_r[ADDR_W-1:0];
    op.read_ok = 1'b0;

    case (func_t'(func))
      FUNC_INSERT: begin
        if (total >= DEPTH_CNT) begin
          op.status = ST_FULL;
        end else begin
          op.wr_en = 1'b1;
          left_nxt = left_r + ONE_CNT;
        end
      end
      FUNC_LEFT: begin
        if (left_r == '0) begin
          op.status = ST_EDGE;
        end else begin
          // move last char of left part to just below the right part
          op.rd_need = 1'b1;
          op.rd_addr = ADDR_W'(left_r - ONE_CNT);
          op.wr_en   = 1'b1;
          op.wr_move = 1'b1;
          op.wr_addr = ADDR_W'(DEPTH_CNT - right_r - ONE_CNT);
          left_nxt   = left_r - ONE_CNT;
          right_nxt  = right_r + ONE_CNT;
        end
      end
      FUNC_RIGHT: begin
        if (right_r == '0) begin
          op.status = ST_EDGE;
        end else begin
          op.rd_need = 1'b1;
          op.rd_addr = ADDR_W'(DEPTH_CNT - right_r);
          op.wr_en   = 1'b1;
          op.wr_move = 1'b1;
          op.wr_addr = left_r[ADDR_W-1:0];
          left_nxt   = left_r + ONE_CNT;
          right_nxt  = right_r - ONE_CNT;
        end
      end
      FUNC_BACKSPACE: begin
        if (left_r == '0) begin
          op.status = ST_EDGE;
        end else begin
          left_nxt = left_r - ONE_CNT;
        end
      end
      FUNC_READ: begin
        if (pos_ext >= total) begin
          op.status = ST_BEYOND;
        end else begin
          op.rd_need = 1'b1;
          op.read_ok = 1'b1;
          op.rd_addr = (pos_ext < left_r) ? pos : ADDR_W'(tail_idx);
        end
      end
      default: begin
      end
    endcase

    new_len     = left_nxt + right_nxt;
    op.text_len = LEN_W'(new_len);
    op.cursor   = LEN_W'(left_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (accept) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gbe_store.sv */
`default_nettype none

module gbe_store (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [gbe_pkg::ADDR_W-1:0]  rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [gbe_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [gbe_pkg::CHAR_W-1:0]  wr_data,
  output logic      [gbe_pkg::CHAR_W-1:0]  rd_data
);
  import gbe_pkg::*;

  logic [CHAR_W-1:0] mem [BUFFER_DEPTH];
  logic [CHAR_W-1:0] mem_q_r;
  logic              fwd_r;
  logic [CHAR_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // read-before-write array: bypass a write landing on the same address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

`default_nettype wire

/* rtl/core/gap_buffer_line_editor.sv */
// Gap buffer line editor: one request in, one result out per request.
// Result path: stage B register at the accept, then the output register, which drives out_*.
// Throughput: one request per cycle; out_stall holds stage B, which then stalls the input.
// A cursor move writes the store in stage B, bypassed to a read at the same edge.
// Reset (synchronous, rst_n low): cursor and length counters clear and the
//   pipeline empties; text store contents stay undefined, no clearing pass.
`default_nettype none

module gap_buffer_line_editor (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gbe_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [gbe_pkg::CHAR_W-1:0]  in_char_in,
  input  wire logic [gbe_pkg::POS_W-1:0]   in_read_pos,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gbe_pkg::CHAR_W-1:0]       out_char_out,
  output logic [gbe_pkg::STATUS_W-1:0]     out_status,
  output logic [gbe_pkg::LEN_W-1:0]        out_text_length,
  output logic [gbe_pkg::LEN_W-1:0]        out_cursor_pos
);
  import gbe_pkg::*;

  // Stage A: request accepted, counters update, store read issued.
  // Stage B: read data back, store written (insert or moved char).
  // Stage C: output register.

  gbe_op_t           op;
  logic              accept;
  logic              b_adv;

  logic              b_valid_r;
  gbe_op_t           b_op_r;
  logic [CHAR_W-1:0] b_char_r;

  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] wr_data;
  logic              wr_en;

  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [LEN_W-1:0]    out_cursor_r;

  // stage B moves on when the output register is empty or being drained
  assign b_adv    = !out_valid_r || !out_stall;
  assign in_stall = b_valid_r && !b_adv;
  assign accept   = in_valid && !in_stall;

  gbe_cmd u_cmd (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_func),
    .pos    (in_read_pos),
    .op     (op)
  );

  // The write of stage B fires exactly once, as the request leaves B.
  assign wr_en   = b_valid_r && b_adv && b_op_r.wr_en;
  assign wr_data = b_op_r.wr_move ? rd_data : b_char_r;

  gbe_store u_store (
    .clk     (clk),
    .rd_en   (accept && op.rd_need),
    .rd_addr (op.rd_addr),
    .wr_en   (wr_en),
    .wr_addr (b_op_r.wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      b_op_r   <= op;
      b_char_r <= in_char_in;
    end
    if (b_adv && b_valid_r) begin
      out_char_r   <= b_op_r.read_ok ? rd_data : '0;
      out_status_r <= b_op_r.status;
      out_len_r    <= b_op_r.text_len;
      out_cursor_r <= b_op_r.cursor;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_status      = out_status_r;
  assign out_text_length = out_len_r;
  assign out_cursor_pos  = out_cursor_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r <= LEN_W'(BUFFER_DEPTH)))
    else $error("text length beyond buffer depth");

  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cursor_r <= out_len_r))
    else $error("cursor beyond text length");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_DONE)) |-> (out_char_r == '0))
    else $error("char_out nonzero on a failed request");

  a_b_held: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_adv) |=> (b_valid_r && $stable(b_op_r)))
    else $error("stage B request lost while output stalled");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  import gbe_pkg::*;

  // Function codes 5..7 are unused by the editor; they must leave state alone.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  // Settle window after the last result.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Watchdog limit for the slowest run (~2.2k requests, long gaps, heavy stall).
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // Expected response for one request, at the port widths.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    status_t           status;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  cur;
  } edit_result_t;

  // Receiver stall patterns, switched after runs of random length.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_STREAK
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  wire logic         in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic [POS_W-1:0]  in_read_pos = '0;
  wire logic         out_valid;
  logic              out_stall = 1'b0;
  wire logic [CHAR_W-1:0]   out_char_out;
  wire logic [STATUS_W-1:0] out_status;
  wire logic [LEN_W-1:0]    out_text_length;
  wire logic [LEN_W-1:0]    out_cursor_pos;

  gap_buffer_line_editor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_char_in      (in_char_in),
    .in_read_pos     (in_read_pos),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_status      (out_status),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow gap buffer. Left part grows up from index 0, right part sits at the
  // top so its last character is always at BUFFER_DEPTH-1.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] shadow_text [BUFFER_DEPTH];
  int unsigned       left_n = 0;
  int unsigned       right_n = 0;

  edit_result_t pending_results [$];
  edit_result_t oldest_result;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  // Sender burst state.
  int unsigned  burst_left = 0;

  // Receiver stall state.
  stall_mode_t  stall_mode = STALL_NONE;
  int unsigned  stall_run = 0;

  // Applies one command to the shadow buffer and returns what the editor
  // should answer.
  function automatic edit_result_t apply_edit(input logic [FUNC_W-1:0] func,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [POS_W-1:0]  pos);
    edit_result_t r;
    int unsigned  idx;
    r.ch     = '0;
    r.status = ST_DONE;
    case (func)
      FUNC_INSERT: begin
        if (left_n + right_n >= BUFFER_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_text[left_n] = ch;
          left_n++;
        end
      end
      FUNC_LEFT: begin
        if (left_n == 0) begin
          r.status = ST_EDGE;
        end else begin
          // char left of the cursor hops across the gap
          shadow_text[BUFFER_DEPTH - right_n - 1] = shadow_text[left_n - 1];
          left_n--;
          right_n++;
        end
      end
      FUNC_RIGHT: begin
        if (right_n == 0) begin
          r.status = ST_EDGE;
        end else begin
          shadow_text[left_n] = shadow_text[BUFFER_DEPTH - right_n];
          left_n++;
          right_n--;
        end
      end
      FUNC_BACKSPACE: begin
        if (left_n == 0) r.status = ST_EDGE;
        else left_n--;
      end
      FUNC_READ: begin
        if (pos >= left_n + right_n) begin
          r.status = ST_BEYOND;
        end else begin
          idx  = (pos < left_n) ? pos : BUFFER_DEPTH - right_n + (pos - left_n);
          r.ch = shadow_text[idx];
        end
      end
      default: ;  // spare codes: no effect
    endcase
    r.len = LEN_W'(left_n + right_n);
    r.cur = LEN_W'(left_n);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Works in bursts; valid may drop between bursts. Valid is
  // lowered only when a real gap follows, so it never gets two updates in one
  // step. The shadow is updated at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [CHAR_W-1:0] ch,
                              input logic [POS_W-1:0]  pos);
    int unsigned idle_gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                               : $urandom_range(1, 12);
      idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (idle_gap > 0) begin
        in_valid <= 1'b0;
        repeat (idle_gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_func     <= func;
    in_char_in  <= ch;
    in_read_pos <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_edit(func, ch, pos));
  endtask

  // Mostly positions inside the text; sometimes anywhere in the field range.
  function automatic logic [POS_W-1:0] pick_read_pos();
    if (left_n + right_n > 0 && $urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, left_n + right_n - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Random editing session; erase_weight tunes whether text grows or shrinks.
  task automatic run_random_edits(input int unsigned count,
                                  input int unsigned erase_weight);
    int unsigned pick;
    logic [FUNC_W-1:0] func;
    repeat (count) begin
      pick = $urandom_range(0, 30 + 14 + 14 + erase_weight + 25 + 3 - 1);
      if (pick < 30)                           func = FUNC_INSERT;
      else if (pick < 44)                      func = FUNC_LEFT;
      else if (pick < 58)                      func = FUNC_RIGHT;
      else if (pick < 58 + erase_weight)       func = FUNC_BACKSPACE;
      else if (pick < 58 + erase_weight + 25)  func = FUNC_READ;
      else func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
      send_request(func, CHAR_W'($urandom_range(0, 255)), pick_read_pos());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty buffer: every move and delete hits an edge, any read is beyond text.
  task automatic test_empty_edges();
    send_request(FUNC_LEFT, 8'h00, '0);
    send_request(FUNC_RIGHT, 8'hFF, '1);
    send_request(FUNC_BACKSPACE, 8'h00, '0);
    send_request(FUNC_READ, 8'h00, '0);
    send_request(FUNC_READ, 8'hFF, '1);
    for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++)
      send_request(FUNC_W'(f), 8'hFF, '1);
  endtask

  // Short text: extreme characters, mid-text insert, both cursor edges.
  task automatic test_basic_edits();
    send_request(FUNC_INSERT, 8'h00, '0);
    send_request(FUNC_INSERT, 8'hFF, '0);
    send_request(FUNC_INSERT, 8'h5A, '0);
    send_request(FUNC_READ, 8'h00, 10'd1);
    send_request(FUNC_READ, 8'h00, 10'd3);       // one past the end
    send_request(FUNC_LEFT, 8'h00, '0);
    send_request(FUNC_LEFT, 8'h00, '0);
    send_request(FUNC_INSERT, 8'hA5, '0);        // lands between 00 and FF
    send_request(FUNC_READ, 8'h00, 10'd1);
    send_request(FUNC_READ, 8'h00, 10'd3);       // served from the right part
    send_request(FUNC_RIGHT, 8'h00, '0);
    send_request(FUNC_RIGHT, 8'h00, '0);
    send_request(FUNC_RIGHT, 8'h00, '0);         // already at end
    send_request(FUNC_BACKSPACE, 8'h00, '0);
    repeat (3) send_request(FUNC_LEFT, 8'h00, '0);
    send_request(FUNC_LEFT, 8'h00, '0);          // at start
    send_request(FUNC_BACKSPACE, 8'h00, '0);     // at start
    send_request(FUNC_READ, 8'h00, 10'd2);
  endtask

  // Bulk random editing with text that slowly grows.
  task automatic test_random_edits();
    run_random_edits(800, 10);
  endtask

  // Fill to capacity with the cursor at the end, so length and cursor reach
  // BUFFER_DEPTH; then poke the full buffer from both sides of the gap.
  task automatic test_fill_buffer();
    int unsigned hops;
    while (right_n != 0) send_request(FUNC_RIGHT, CHAR_W'($urandom_range(0, 255)), '0);
    while (left_n + right_n < BUFFER_DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        send_request(FUNC_READ, 8'h00, pick_read_pos());
      else
        send_request(FUNC_INSERT, CHAR_W'($urandom_range(0, 255)), pick_read_pos());
    end
    send_request(FUNC_INSERT, 8'hFF, '1);        // refused: full
    send_request(FUNC_READ, 8'h00, '1);          // last slot of the store
    send_request(FUNC_READ, 8'h00, '0);
    send_request(FUNC_RIGHT, 8'h00, '0);         // full and at end
    hops = $urandom_range(3, 40);
    repeat (hops) send_request(FUNC_LEFT, CHAR_W'($urandom_range(0, 255)), '0);
    send_request(FUNC_INSERT, 8'h00, '0);        // refused with cursor mid-text
    send_request(FUNC_READ, 8'h00, '1);
    repeat (4) send_request(FUNC_READ, 8'h00, pick_read_pos());
    send_request(FUNC_BACKSPACE, 8'h00, '0);
    send_request(FUNC_INSERT, 8'h3C, '0);        // refills the last slot
    send_request(FUNC_INSERT, 8'hC3, '0);        // refused again
    repeat (hops) send_request(FUNC_RIGHT, 8'h00, '0);
    send_request(FUNC_RIGHT, 8'h00, '0);
  endtask

  // Shrink the text again with a delete-heavy random mix.
  task automatic test_drain_edits();
    run_random_edits(150, 60);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, independent of out_valid.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_run  = $urandom_range(8, 200);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_run % 16) < 10);  // long stall runs
    endcase
  end

  // ---------------------------------------------------------------------------
  // Response checker: in-order compare against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("response with no request pending (status %0d)",
                                  out_status));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_char_out !== oldest_result.ch)
          report_mismatch($sformatf("char_out got %0h expected %0h",
                                    out_char_out, oldest_result.ch));
        if (out_status !== oldest_result.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_status, oldest_result.status));
        if (out_text_length !== oldest_result.len)
          report_mismatch($sformatf("text_length got %0d expected %0d",
                                    out_text_length, oldest_result.len));
        if (out_cursor_pos !== oldest_result.cur)
          report_mismatch($sformatf("cursor_pos got %0d expected %0d",
                                    out_cursor_pos, oldest_result.cur));
      end
    end
  end

  // Watchdog; also catches predictions that never get a response.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_edges();
    test_basic_edits();
    test_random_edits();
    test_fill_buffer();
    test_drain_edits();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/gbe_pkg.sv
rtl/core/gbe_cmd.sv
rtl/core/gbe_store.sv
rtl/core/gap_buffer_line_editor.sv
test/testbench.sv
